// ===== design/ecomp_pkg.sv =====
`default_nettype none
package ecomp_pkg;

	localparam int DW = 64;
	localparam int DIV_STAGES = DW;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHUM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM = 3'd4;

	localparam logic [19:0] SKIP_TP = 20'h80000;
	localparam logic [15:0] SKIP_H = 16'h8000;

	localparam logic signed [32:0] P_TOFS = 33'sd128000;
	localparam logic [31:0] H_TOFS = 32'd76800;
	localparam logic [20:0] P_RAW_TOP = 21'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic signed [63:0] P_BIAS = 64'sh0000_8000_0000_0000;
	localparam logic [31:0] H_ROUND = 32'd16384;
	localparam logic [31:0] H_HALF = 32'd32768;
	localparam logic [31:0] H_OFS2 = 32'd2097152;
	localparam logic [31:0] H_ROUND2 = 32'd8192;
	localparam logic [31:0] H_MAX = 32'd419430400;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic [11:0]        h4;
		logic [11:0]        h5;
		logic signed [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic [31:0] tc;
		logic        tvalid;
		logic        pvalid;
		logic        dz;
		logic        hvalid;
		logic [31:0] hv2;
		logic [31:0] ht;
	} side_t;

	typedef struct packed {
		logic [DW-1:0] num;
		logic [DW-1:0] den;
		logic          neg;
		side_t         side;
	} div_in_t;

	typedef struct packed {
		logic [DW-1:0] quo;
		logic          neg;
		side_t         side;
	} div_out_t;

	typedef struct packed {
		logic [31:0] tc;
		logic        tvalid;
		logic [31:0] pres;
		logic        pvalid;
		logic        dz;
		logic [16:0] hum;
		logic        hvalid;
	} res_t;

endpackage
`default_nettype wire

// ===== design/ecomp_in_if.sv =====
`default_nettype none
interface ecomp_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;

	modport source(output valid, output raw_temperature, output raw_pressure,
		output raw_humidity, input ready);
	modport sink(input valid, input raw_temperature, input raw_pressure,
		input raw_humidity, output ready);
endinterface
`default_nettype wire

// ===== design/ecomp_out_if.sv =====
`default_nettype none
interface ecomp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic               temperature_valid;
	logic signed [31:0] pressure_pa;
	logic               pressure_valid;
	logic               pressure_div_zero;
	logic [16:0]        humidity_q10;
	logic               humidity_valid;

	modport source(output valid, output temperature_centi, output temperature_valid,
		output pressure_pa, output pressure_valid, output pressure_div_zero,
		output humidity_q10, output humidity_valid, input ready);
	modport sink(input valid, input temperature_centi, input temperature_valid,
		input pressure_pa, input pressure_valid, input pressure_div_zero,
		input humidity_q10, input humidity_valid, output ready);
endinterface
`default_nettype wire

// ===== design/ecomp_front.sv =====
`default_nettype none
module ecomp_front import ecomp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire cal_t        cal,
	input  wire logic        in_vld,
	input  wire logic [19:0] raw_t,
	input  wire logic [19:0] raw_p,
	input  wire logic [15:0] raw_h,
	output logic             out_vld,
	output div_in_t          dout
);

	localparam int NS = 10;

	logic [NS:1] vld_s;

	logic [2:0] flg_s1, flg_s2, flg_s3, flg_s4, flg_s5, flg_s6, flg_s7, flg_s8, flg_s9, flg_s10;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;

	logic [31:0] m1_s1, dd_s1;
	logic [31:0] v1_s2, m2_s2;
	logic [31:0] tf_s3;
	logic [31:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic signed [32:0] a_s4;
	logic [31:0] hv_s4;

	logic signed [63:0] aa_s5, ap5_s5, ap2_s5;
	logic [31:0] h5v_s5, vh6_s5, vh3_s5;

	logic signed [63:0] bp_s6, aap3_s6, ap5_s6, ap2_s6;
	logic [31:0] x_s6, y1_s6;

	logic signed [63:0] b_s7, a2_s7;
	logic [31:0] y2_s7, x_s7;

	logic signed [63:0] m_s8;
	logic [63:0] nr_s8;
	logic [31:0] v2_s8;

	logic [63:0] num_s9;
	logic [63:0] den_s9;
	logic [31:0] ss_s9, v2_s9;

	logic [63:0] num_s10, den_s10;
	logic        neg_s10, dz_s10;
	logic [31:0] ht_s10, v2_s10;

	logic [31:0] x1, d0, sh;
	logic [20:0] np;

	always_comb begin
		x1 = 32'(raw_t[19:3]) - {15'b0, cal.t1, 1'b0};
		d0 = 32'(raw_t[19:4]) - 32'(cal.t1);
		np = P_RAW_TOP - {1'b0, rp_s7};
		sh = 32'($signed(v2_s8) >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature
			m1_s1 <= x1 * 32'(cal.t2);
			dd_s1 <= d0 * d0;
			flg_s1 <= {raw_t != SKIP_TP, raw_p != SKIP_TP, raw_h != SKIP_H};
			rp_s1 <= raw_p;
			rh_s1 <= raw_h;

			v1_s2 <= 32'($signed(m1_s1) >>> 11);
			m2_s2 <= 32'($signed(dd_s1) >>> 12) * 32'(cal.t3);
			flg_s2 <= flg_s1;
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;

			tf_s3 <= v1_s2 + 32'($signed(m2_s2) >>> 14);
			flg_s3 <= flg_s2;
			rp_s3 <= rp_s2;
			rh_s3 <= rh_s2;

			tc_s4 <= 32'($signed(tf_s3 * 32'd5 + 32'd128) >>> 8);
			a_s4 <= 33'($signed(tf_s3)) - P_TOFS;
			hv_s4 <= tf_s3 - H_TOFS;
			flg_s4 <= flg_s3;
			rp_s4 <= rp_s3;
			rh_s4 <= rh_s3;

			// pressure and humidity products
			aa_s5 <= a_s4 * a_s4;
			ap5_s5 <= a_s4 * cal.p5;
			ap2_s5 <= a_s4 * cal.p2;
			h5v_s5 <= 32'(cal.h5) * hv_s4;
			vh6_s5 <= hv_s4 * 32'(cal.h6);
			vh3_s5 <= hv_s4 * 32'(cal.h3);
			tc_s5 <= tc_s4;
			flg_s5 <= flg_s4;
			rp_s5 <= rp_s4;
			rh_s5 <= rh_s4;

			bp_s6 <= aa_s5 * cal.p6;
			aap3_s6 <= aa_s5 * cal.p3;
			ap5_s6 <= ap5_s5;
			ap2_s6 <= ap2_s5;
			x_s6 <= 32'($signed(({16'b0, rh_s5} << 14) - ({20'b0, cal.h4} << 20)
				- h5v_s5 + H_ROUND) >>> 15);
			y1_s6 <= 32'($signed(vh6_s5) >>> 10) * (32'($signed(vh3_s5) >>> 11) + H_HALF);
			tc_s6 <= tc_s5;
			flg_s6 <= flg_s5;
			rp_s6 <= rp_s5;

			b_s7 <= bp_s6 + (ap5_s6 <<< 17) + (64'(cal.p4) <<< 35);
			a2_s7 <= (aap3_s6 >>> 8) + (ap2_s6 <<< 12);
			y2_s7 <= (32'($signed(y1_s6) >>> 10) + H_OFS2) * 32'(cal.h2);
			x_s7 <= x_s6;
			tc_s7 <= tc_s6;
			flg_s7 <= flg_s6;
			rp_s7 <= rp_s6;

			m_s8 <= (P_BIAS + a2_s7) * $signed({1'b0, cal.p1});
			nr_s8 <= ({43'b0, np} << 31) - b_s7;
			v2_s8 <= x_s7 * 32'($signed(y2_s7 + H_ROUND2) >>> 14);
			tc_s8 <= tc_s7;
			flg_s8 <= flg_s7;

			num_s9 <= nr_s8 * P_SCALE;
			den_s9 <= 64'(m_s8 >>> 33);
			ss_s9 <= sh * sh;
			v2_s9 <= v2_s8;
			tc_s9 <= tc_s8;
			flg_s9 <= flg_s8;

			// divider takes magnitudes and the sign of the quotient
			num_s10 <= num_s9[63] ? -num_s9 : num_s9;
			den_s10 <= den_s9[63] ? -den_s9 : den_s9;
			neg_s10 <= num_s9[63] ^ den_s9[63];
			dz_s10 <= (den_s9 == '0);
			ht_s10 <= 32'($signed(ss_s9) >>> 7) * 32'(cal.h1);
			v2_s10 <= v2_s9;
			tc_s10 <= tc_s9;
			flg_s10 <= flg_s9;
		end
	end

	always_comb begin
		out_vld = vld_s[NS];
		dout.num = num_s10;
		dout.den = den_s10;
		dout.neg = neg_s10;
		dout.side.tc = tc_s10;
		dout.side.tvalid = flg_s10[2];
		dout.side.pvalid = flg_s10[1];
		dout.side.dz = dz_s10;
		dout.side.hvalid = flg_s10[0];
		dout.side.hv2 = v2_s10;
		dout.side.ht = ht_s10;
	end

endmodule
`default_nettype wire

// ===== design/ecomp_div.sv =====
`default_nettype none
module ecomp_div import ecomp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_vld,
	input  wire div_in_t din,
	output logic         out_vld,
	output div_out_t     dout
);

	localparam int N = DIV_STAGES;

	typedef struct packed {
		logic  neg;
		side_t side;
	} tag_t;

	// One quotient bit per stage, restoring division on magnitudes.
	logic [N-1:0]  vld_s;
	logic [DW-1:0] rem_s [N-1];
	logic [DW-1:0] den_s [N-1];
	logic [DW-1:0] quo_s [N];
	tag_t          tag_s [N];

	logic [DW-1:0] r_in [N];
	logic [DW-1:0] n_in [N];
	logic [DW-1:0] d_in [N];
	tag_t          t_in [N];
	logic [DW+1:0] dif [N];
	logic [DW-1:0] r_nx [N];
	logic [DW-1:0] n_nx [N];

	always_comb begin
		r_in[0] = '0;
		n_in[0] = din.num;
		d_in[0] = din.den;
		t_in[0] = '{neg: din.neg, side: din.side};
		for (int k = 1; k < N; k++) begin
			r_in[k] = rem_s[k-1];
			n_in[k] = quo_s[k-1];
			d_in[k] = den_s[k-1];
			t_in[k] = tag_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			dif[k] = {1'b0, r_in[k], n_in[k][DW-1]} - {2'b00, d_in[k]};
			r_nx[k] = dif[k][DW+1] ? {r_in[k][DW-2:0], n_in[k][DW-1]} : dif[k][DW-1:0];
			n_nx[k] = {n_in[k][DW-2:0], ~dif[k][DW+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N - 1; k++) begin
				rem_s[k] <= r_nx[k];
				den_s[k] <= d_in[k];
			end
			for (int k = 0; k < N; k++) begin
				quo_s[k] <= n_nx[k];
				tag_s[k] <= t_in[k];
			end
		end
	end

	always_comb begin
		out_vld = vld_s[N-1];
		dout.quo = quo_s[N-1];
		dout.neg = tag_s[N-1].neg;
		dout.side = tag_s[N-1].side;
	end

endmodule
`default_nettype wire

// ===== design/ecomp_back.sv =====
`default_nettype none
module ecomp_back import ecomp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire cal_t     cal,
	input  wire logic     in_vld,
	input  wire div_out_t din,
	output logic          out_vld,
	output res_t          res
);

	localparam int NS = 7;

	logic [NS:1] vld_s;

	res_t info_b1, info_b2, info_b3, info_b4, info_b5, info_b6, res_b7;

	logic signed [63:0] p_b1, p_b2, p_b3, p_b4;
	logic signed [63:0] q_b2, pq_b2, c2_b2, c2_b3, c2_b4;
	logic [63:0] ll_b3;
	logic [31:0] lh_b3, hl_b3;
	logic signed [63:0] pr_b4;
	logic signed [63:0] s_b5;
	logic signed [63:0] r_b6;

	logic [31:0] hv3, hcl;
	logic signed [63:0] q_c;
	logic [63:0] rr;

	always_comb begin
		hv3 = din.side.hv2 - 32'($signed(din.side.ht) >>> 4);
		if (hv3[31]) begin
			hcl = '0;
		end else if (hv3 > H_MAX) begin
			hcl = H_MAX;
		end else begin
			hcl = hv3;
		end
		q_c = p_b1 >>> 13;
		// division by 256 that truncates toward zero
		rr = 64'((r_b6 + (r_b6[63] ? 64'sd255 : 64'sd0)) >>> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_b1 <= din.neg ? -$signed(din.quo) : $signed(din.quo);
			info_b1.tc <= din.side.tc;
			info_b1.tvalid <= din.side.tvalid;
			info_b1.pres <= '0;
			info_b1.pvalid <= din.side.pvalid;
			info_b1.dz <= din.side.dz;
			info_b1.hum <= 17'(hcl >> 12);
			info_b1.hvalid <= din.side.hvalid;

			q_b2 <= q_c;
			pq_b2 <= q_c * cal.p9;
			c2_b2 <= p_b1 * cal.p8;
			p_b2 <= p_b1;
			info_b2 <= info_b1;

			// low 64 bits of a 64 by 64 product from 32-bit partial products
			ll_b3 <= 64'(pq_b2[31:0]) * 64'(q_b2[31:0]);
			lh_b3 <= pq_b2[31:0] * q_b2[63:32];
			hl_b3 <= pq_b2[63:32] * q_b2[31:0];
			p_b3 <= p_b2;
			c2_b3 <= c2_b2;
			info_b3 <= info_b2;

			pr_b4 <= ll_b3 + {lh_b3 + hl_b3, 32'b0};
			p_b4 <= p_b3;
			c2_b4 <= c2_b3;
			info_b4 <= info_b3;

			s_b5 <= p_b4 + (pr_b4 >>> 25) + (c2_b4 >>> 19);
			info_b5 <= info_b4;

			r_b6 <= (s_b5 >>> 8) + (64'(cal.p7) <<< 4);
			info_b6 <= info_b5;

			res_b7.tc <= info_b6.tvalid ? info_b6.tc : '0;
			res_b7.tvalid <= info_b6.tvalid;
			res_b7.pres <= (info_b6.pvalid && !info_b6.dz) ? rr[31:0] : '0;
			res_b7.pvalid <= info_b6.pvalid;
			res_b7.dz <= info_b6.pvalid && info_b6.dz;
			res_b7.hum <= info_b6.hvalid ? info_b6.hum : '0;
			res_b7.hvalid <= info_b6.hvalid;
		end
	end

	always_comb begin
		out_vld = vld_s[NS];
		res = res_b7;
	end

endmodule
`default_nettype wire

// ===== design/environment_sensor_compensation_top.sv =====
// Integer compensation of one raw temperature, pressure and humidity sample.
// Samples enter on the sample channel and compensated results leave on the
// result channel; both use valid/ready and a transfer happens when both are
// high at a rising clock edge. Calibration words are written through the
// cfg_we/cfg_index/cfg_data port; the user must write them only while no
// sample is in flight, which the block does not enforce. The datapath is a
// single pipeline: ten stages of temperature, humidity and pressure
// pre-division arithmetic, a 64-stage divider that resolves one quotient
// bit per stage, and seven stages of pressure post-processing. Throughput
// is one sample per cycle unless stalled; the pressure divider sets the
// depth. When the receiver stalls a result that is shown, the whole
// pipeline holds and sample.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and the calibration registers to zero.
`default_nettype none
module environment_sensor_compensation_top import ecomp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	ecomp_in_if.sink                  sample,
	ecomp_out_if.source               result
);

	logic [47:0] cal_temp_q;
	logic [63:0] cal_plow_q;
	logic [63:0] cal_phigh_q;
	logic [47:0] cal_phum_q;
	logic [31:0] cal_hum_q;
	cal_t        cal;

	logic     en;
	logic     fr_vld, dv_vld, bk_vld;
	div_in_t  fr_out;
	div_out_t dv_out;
	res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			cal_plow_q <= '0;
			cal_phigh_q <= '0;
			cal_phum_q <= '0;
			cal_hum_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP: cal_temp_q <= cfg_data[47:0];
				CFG_PLOW: cal_plow_q <= cfg_data;
				CFG_PHIGH: cal_phigh_q <= cfg_data;
				CFG_PHUM: cal_phum_q <= cfg_data[47:0];
				CFG_HUM: cal_hum_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = cal_temp_q[15:0];
		cal.t2 = cal_temp_q[31:16];
		cal.t3 = cal_temp_q[47:32];
		cal.p1 = cal_plow_q[15:0];
		cal.p2 = cal_plow_q[31:16];
		cal.p3 = cal_plow_q[47:32];
		cal.p4 = cal_plow_q[63:48];
		cal.p5 = cal_phigh_q[15:0];
		cal.p6 = cal_phigh_q[31:16];
		cal.p7 = cal_phigh_q[47:32];
		cal.p8 = cal_phigh_q[63:48];
		cal.p9 = cal_phum_q[15:0];
		cal.h1 = cal_phum_q[23:16];
		cal.h2 = cal_phum_q[39:24];
		cal.h3 = cal_phum_q[47:40];
		cal.h4 = cal_hum_q[11:0];
		cal.h5 = cal_hum_q[23:12];
		cal.h6 = cal_hum_q[31:24];
	end

	// The pipeline advances unless a shown result is being held off.
	assign en = !bk_vld || result.ready;
	assign sample.ready = en;

	ecomp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cal    (cal),
		.in_vld (sample.valid),
		.raw_t  (sample.raw_temperature),
		.raw_p  (sample.raw_pressure),
		.raw_h  (sample.raw_humidity),
		.out_vld(fr_vld),
		.dout   (fr_out)
	);

	ecomp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (fr_vld),
		.din    (fr_out),
		.out_vld(dv_vld),
		.dout   (dv_out)
	);

	ecomp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cal    (cal),
		.in_vld (dv_vld),
		.din    (dv_out),
		.out_vld(bk_vld),
		.res    (res)
	);

	always_comb begin
		result.valid = bk_vld;
		result.temperature_centi = res.tc;
		result.temperature_valid = res.tvalid;
		result.pressure_pa = res.pres;
		result.pressure_valid = res.pvalid;
		result.pressure_div_zero = res.dz;
		result.humidity_q10 = res.hum;
		result.humidity_valid = res.hvalid;
	end

endmodule
`default_nettype wire

// ===== test/environment_sensor_compensation_top_test.sv =====
`timescale 1ns / 1ps
module environment_sensor_compensation_top_test;
	import ecomp_pkg::*;

	typedef struct packed {
		logic [19:0] t;
		logic [19:0] p;
		logic [15:0] h;
	} raw_sample_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	ecomp_in_if sample();
	ecomp_out_if result();

	environment_sensor_compensation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample.sink),
		.result(result.source)
	);

	raw_sample_t pending_samples[$];
	res_t expected_results[$];
	logic [63:0] cal_words[5];
	int unsigned send_gap;
	int unsigned recv_stall;
	bit no_idle;
	int errors;
	int checked;
	int dz_seen;
	int clamped_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** environment_sensor_compensation_top: FAILED **");
		$finish;
	end

	function automatic logic [31:0] asr32(logic [31:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	// Signed division truncating toward zero, done on magnitudes so that the
	// most negative dividend wraps the same way as two's complement would.
	function automatic logic [63:0] div_trunc64(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] ^ b[63]) ? -q : q;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic res_t compensate(raw_sample_t s);
		res_t r;
		logic [31:0] t1, t2, t3, at, d, v1, v2, tfine, tcenti;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] a, b, p, q, c1, c2;
		logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, sq;
		logic [63:0] ct, cl, ch, cph, chm;
		ct = cal_words[CFG_TEMP];
		cl = cal_words[CFG_PLOW];
		ch = cal_words[CFG_PHIGH];
		cph = cal_words[CFG_PHUM];
		chm = cal_words[CFG_HUM];
		r = '0;

		at = {12'd0, s.t};
		t1 = {16'd0, ct[15:0]};
		t2 = {{16{ct[31]}}, ct[31:16]};
		t3 = {{16{ct[47]}}, ct[47:32]};
		v1 = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		v2 = asr32(asr32(d * d, 12) * t3, 14);
		tfine = v1 + v2;
		tcenti = asr32(tfine * 32'd5 + 32'd128, 8);
		r.tvalid = (s.t != SKIP_TP);
		r.tc = r.tvalid ? tcenti : 32'd0;

		p1 = {48'd0, cl[15:0]};
		p2 = {{48{cl[31]}}, cl[31:16]};
		p3 = {{48{cl[47]}}, cl[47:32]};
		p4 = {{48{cl[63]}}, cl[63:48]};
		p5 = {{48{ch[15]}}, ch[15:0]};
		p6 = {{48{ch[31]}}, ch[31:16]};
		p7 = {{48{ch[47]}}, ch[47:32]};
		p8 = {{48{ch[63]}}, ch[63:48]};
		p9 = {{48{cph[15]}}, cph[15:0]};
		r.pvalid = (s.p != SKIP_TP);
		if (r.pvalid) begin
			a = {{32{tfine[31]}}, tfine} - 64'd128000;
			b = a * a * p6;
			b = b + ((a * p5) << 17);
			b = b + (p4 << 35);
			a = asr64(a * a * p3, 8) + ((a * p2) << 12);
			a = asr64(((64'd1 << 47) + a) * p1, 33);
			if (a == 64'd0) begin
				r.dz = 1'b1;
			end else begin
				p = 64'd1048576 - {44'd0, s.p};
				p = div_trunc64(((p << 31) - b) * 64'd3125, a);
				q = asr64(p, 13);
				c1 = asr64(p9 * q * q, 25);
				c2 = asr64(p8 * p, 19);
				p = asr64(p + c1 + c2, 8) + (p7 << 4);
				p = div_trunc64(p, 64'd256);
				r.pres = p[31:0];
			end
		end

		h1 = {24'd0, cph[23:16]};
		h2 = {{16{cph[39]}}, cph[39:24]};
		h3 = {24'd0, cph[47:40]};
		h4 = {20'd0, chm[11:0]};
		h5 = {20'd0, chm[23:12]};
		h6 = {{24{chm[31]}}, chm[31:24]};
		r.hvalid = (s.h != SKIP_H);
		if (r.hvalid) begin
			v = tfine - 32'd76800;
			x = asr32(({16'd0, s.h} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
			y = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768);
			y = (asr32(y, 10) + 32'd2097152) * h2 + 32'd8192;
			y = asr32(y, 14);
			v = x * y;
			sq = asr32(v, 15);
			v = v - asr32(asr32(sq * sq, 7) * h1, 4);
			if (v[31])
				v = 32'd0;
			if (v > 32'd419430400)
				v = 32'd419430400;
			r.hum = v[28:12];
		end
		return r;
	endfunction

	// Sample driver: a new sample is shown only after the previous transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.raw_temperature <= '0;
			sample.raw_pressure <= '0;
			sample.raw_humidity <= '0;
			send_gap <= 0;
		end else if (!sample.valid || sample.ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				sample.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				raw_sample_t s;
				s = pending_samples.pop_front();
				sample.raw_temperature <= s.t;
				sample.raw_pressure <= s.p;
				sample.raw_humidity <= s.h;
				sample.valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			recv_stall <= 0;
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			recv_stall <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample.valid && sample.ready)
			expected_results.push_back(compensate({sample.raw_temperature,
				sample.raw_pressure, sample.raw_humidity}));
		if (arst_n && result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected", $time);
			end else begin
				res_t e;
				res_t g;
				e = expected_results.pop_front();
				g.tc = result.temperature_centi;
				g.tvalid = result.temperature_valid;
				g.pres = result.pressure_pa;
				g.pvalid = result.pressure_valid;
				g.dz = result.pressure_div_zero;
				g.hum = result.humidity_q10;
				g.hvalid = result.humidity_valid;
				checked++;
				if (e.dz)
					dz_seen++;
				if (e.hvalid && (e.hum == 17'd0 || e.hum == 17'd102400))
					clamped_seen++;
				if (g !== e) begin
					errors++;
					$display("%0t: mismatch expected t=%0d/%b p=%0d/%b/%b h=%0d/%b", $time,
						$signed(e.tc), e.tvalid, $signed(e.pres), e.pvalid, e.dz,
						e.hum, e.hvalid);
					$display("%0t:          actual t=%0d/%b p=%0d/%b/%b h=%0d/%b", $time,
						$signed(g.tc), g.tvalid, $signed(g.pres), g.pvalid, g.dz,
						g.hum, g.hvalid);
				end
			end
		end
	end

	task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TEMP: cal_words[CFG_TEMP] = val & 64'hFFFF_FFFF_FFFF;
			CFG_PLOW: cal_words[CFG_PLOW] = val;
			CFG_PHIGH: cal_words[CFG_PHIGH] = val;
			CFG_PHUM: cal_words[CFG_PHUM] = val & 64'hFFFF_FFFF_FFFF;
			CFG_HUM: cal_words[CFG_HUM] = val & 64'hFFFF_FFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Returns once every queued sample has been sent and every result checked.
	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (pending_samples.size() != 0 || sample.valid || expected_results.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic load_typical(logic [15:0] p1);
		write_cal(CFG_TEMP, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
		write_cal(CFG_PLOW, {16'd2855, 16'd3024, 16'hD643, p1});
		write_cal(CFG_PHIGH, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
		write_cal(CFG_PHUM, {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000});
		write_cal(CFG_HUM, {32'd0, 8'd30, 12'd50, 12'd313});
	endtask

	function automatic raw_sample_t random_sample();
		raw_sample_t s;
		if ($urandom_range(0, 99) < 65) begin
			s.t = $urandom_range(440000, 600000);
			s.p = $urandom_range(250000, 480000);
			s.h = $urandom_range(20000, 45000);
		end else begin
			s.t = $urandom;
			s.p = $urandom;
			s.h = $urandom;
		end
		if ($urandom_range(0, 19) == 0)
			s.t = SKIP_TP;
		if ($urandom_range(0, 19) == 0)
			s.p = SKIP_TP;
		if ($urandom_range(0, 19) == 0)
			s.h = SKIP_H;
		return s;
	endfunction

	task automatic push_random(int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	task automatic push_directed();
		pending_samples.push_back('{20'd0, 20'd0, 16'd0});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
		pending_samples.push_back('{SKIP_TP, SKIP_TP, SKIP_H});
		pending_samples.push_back('{SKIP_TP, 20'd415148, 16'd30000});
		pending_samples.push_back('{20'd519888, SKIP_TP, 16'd30000});
		pending_samples.push_back('{20'd519888, 20'd415148, SKIP_H});
		pending_samples.push_back('{20'h7FFFF, 20'h80001, 16'h7FFF});
		pending_samples.push_back('{20'h80001, 20'h7FFFF, 16'h8001});
		pending_samples.push_back('{20'd519888, 20'd415148, 16'd0});
		pending_samples.push_back('{20'd519888, 20'd415148, 16'hFFFF});
		pending_samples.push_back('{20'd519888, 20'd415148, 16'd30000});
		pending_samples.push_back('{20'd300000, 20'd100000, 16'd60000});
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 1'b0;
		errors = 0;
		checked = 0;
		dz_seen = 0;
		clamped_seen = 0;
		foreach (cal_words[i])
			cal_words[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// All calibration words still zero: every valid pressure divides by zero.
		push_directed();
		wait_drained();

		load_typical(16'd36477);
		write_cal(3'd5, {$urandom, $urandom});
		write_cal(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		push_directed();
		push_random(120);
		// Let the whole pipeline empty before sending the rest of this setting.
		wait_drained();
		push_random(120);
		wait_drained();

		no_idle = 1'b1;
		for (int i = 0; i < 5; i++)
			write_cal(i[CFG_IDX_W-1:0], 64'hFFFF_FFFF_FFFF_FFFF);
		push_directed();
		push_random(50);
		wait_drained();
		no_idle = 1'b0;

		load_typical(16'd0);
		push_random(40);
		wait_drained();

		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 5; i++)
				write_cal(i[CFG_IDX_W-1:0], {$urandom, $urandom});
			no_idle = (k == 3);
			push_random(30);
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("Checked %0d results over zero, typical, all-ones, P1-zero and random", checked);
		$display("calibrations; %0d had a zero divisor, %0d humidity at a clamp limit.",
			dz_seen, clamped_seen);
		if (errors == 0)
			$display("** environment_sensor_compensation_top: PASSED **");
		else
			$display("** environment_sensor_compensation_top: FAILED **");
		$finish;
	end

endmodule

// ===== environment_sensor_compensation_top.f =====
design/ecomp_pkg.sv
design/ecomp_in_if.sv
design/ecomp_out_if.sv
design/ecomp_front.sv
design/ecomp_div.sv
design/ecomp_back.sv
design/environment_sensor_compensation_top.sv
test/environment_sensor_compensation_top_test.sv
